[design/csv_line_frame_crc_checker_defines.svh]
// Assertion macros for the line frame checker.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef CSV_LINE_FRAME_CRC_CHECKER_DEFINES_SVH
`define CSV_LINE_FRAME_CRC_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define CLFCC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clfcc: same-cycle check failed");

// Next-cycle implication
`define CLFCC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clfcc: next-cycle check failed");

`else

`define CLFCC_ASSERT_IMP(label, ante, cons)
`define CLFCC_ASSERT_NXT(label, ante, cons)

`endif

`endif

[design/clfcc_pkg.sv]
package clfcc_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 10;
    localparam int CRC_W   = 16;
    localparam int TAIL_W  = 17;
    localparam int IDX_W   = 4;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_MAX_LINE_BYTES = 4'd0;
    localparam logic [IDX_W-1:0] REG_SENSOR_FIELDS  = 4'd1;
    localparam logic [IDX_W-1:0] REG_EST_FIELDS     = 4'd2;
    localparam logic [IDX_W-1:0] REG_CALIB_FIELDS   = 4'd3;

    // Configuration reset values
    localparam logic [CNT_W-1:0] MAX_LINE_RST      = 10'd512;
    localparam logic [CNT_W-1:0] SENSOR_FIELDS_RST = 10'd17;
    localparam logic [CNT_W-1:0] EST_FIELDS_RST    = 10'd15;
    localparam logic [CNT_W-1:0] CALIB_FIELDS_RST  = 10'd6;

    // Verdict codes
    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_FRAMING   = 3'd1;
    localparam logic [2:0] VERDICT_CRC       = 3'd2;
    localparam logic [2:0] VERDICT_FEW       = 3'd3;
    localparam logic [2:0] VERDICT_MANY      = 3'd4;
    localparam logic [2:0] VERDICT_BAD_CALIB = 3'd5;

    // Frame kind codes
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_SENSOR  = 2'd1;
    localparam logic [1:0] KIND_EST     = 2'd2;
    localparam logic [1:0] KIND_CALIB   = 2'd3;

    // Characters
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CHAR_Z     = 8'h5A;

    // CRC and tail constants
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 10'd1023;
    localparam logic [TAIL_W-1:0] TAIL_SAT  = 17'd65536;

    // One result
    typedef struct packed {
        logic [2:0]       verdict;
        logic [1:0]       frame_kind;
        logic [CNT_W-1:0] field_total;
        logic [CRC_W-1:0] crc_value;
    } result_t;

    // CRC-16/CCITT-FALSE update over one byte, MSB first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/clfcc_if.sv]
// Received byte channel
interface clfcc_byte_if;
    logic                         valid;
    logic                         ready;
    logic [clfcc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Verdict channel
interface clfcc_result_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  verdict;
    logic [1:0]                  frame_kind;
    logic [clfcc_pkg::CNT_W-1:0] field_total;
    logic [clfcc_pkg::CRC_W-1:0] crc_value;

    modport source (output valid, output verdict, output frame_kind, output field_total,
                    output crc_value, input ready);
    modport sink   (input valid, input verdict, input frame_kind, input field_total,
                    input crc_value, output ready);
endinterface

// Configuration write channel
interface clfcc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [clfcc_pkg::IDX_W-1:0] index;
    logic [clfcc_pkg::CNT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/csv_line_frame_crc_checker.sv]
// A newline (or overrunning) byte is held in the input register; its verdict is then written to
// the result register, which raises the verdict request.
// Throughput: one byte per cycle but for the stall below; input register, combinational CRC/parse
// update, result register. A pending verdict blocked downstream stalls the byte stage only when
// it holds another verdict. Reset (rst_n low, asynchronous): line state cleared, registers back
// to 512/17/15/6, both pipeline stages empty. Configuration writes are always taken.
`include "csv_line_frame_crc_checker_defines.svh"

module csv_line_frame_crc_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    clfcc_byte_if.sink            rx,
    clfcc_result_if.source        result,
    clfcc_cfg_if.sink             cfg
);

    // Configuration registers
    logic [clfcc_pkg::CNT_W-1:0] max_line_reg;
    logic [clfcc_pkg::CNT_W-1:0] sensor_fields_reg;
    logic [clfcc_pkg::CNT_W-1:0] est_fields_reg;
    logic [clfcc_pkg::CNT_W-1:0] calib_fields_reg;

    // Input stage
    logic                         in_valid_reg;
    logic [clfcc_pkg::BYTE_W-1:0] in_byte_reg;

    // Output stage
    logic              out_valid_reg;
    clfcc_pkg::result_t out_reg;
    clfcc_pkg::result_t res_next;

    // Line state
    logic [clfcc_pkg::CRC_W-1:0]  running_crc_reg, running_crc_next;
    logic [clfcc_pkg::CRC_W-1:0]  comma_crc_reg, comma_crc_next;
    logic                         comma_seen_reg, comma_seen_next;
    logic [clfcc_pkg::TAIL_W-1:0] tail_value_reg, tail_value_next;
    logic                         tail_empty_reg, tail_empty_next;
    logic                         tail_bad_reg, tail_bad_next;
    logic [clfcc_pkg::CNT_W-1:0]  line_bytes_reg, line_bytes_next;
    logic [clfcc_pkg::CNT_W-1:0]  comma_total_reg, comma_total_next;
    logic                         return_seen_reg, return_seen_next;
    logic [clfcc_pkg::BYTE_W-1:0] lead_char_reg, lead_char_next;
    logic [1:0]                   lead_len_reg, lead_len_next;

    // Datapath
    logic [clfcc_pkg::CNT_W:0]    line_inc;
    logic                         overrun;
    logic                         is_nl;
    logic                         has_result;
    logic                         out_free;
    logic                         s1_fire;
    logic [clfcc_pkg::CRC_W-1:0]  crc_new;
    logic                         is_digit;
    logic [20:0]                  tail_acc;
    logic [clfcc_pkg::CNT_W-1:0]  fields;
    logic [1:0]                   kind;
    logic                         tail_ok;
    logic [clfcc_pkg::CRC_W-1:0]  rcrc;
    logic [clfcc_pkg::CNT_W-1:0]  expected;
    logic [2:0]                   verdict;

    // Handshake
    assign line_inc   = {1'b0, line_bytes_reg} + 11'd1;
    assign overrun    = line_inc > {1'b0, max_line_reg};
    assign is_nl      = in_byte_reg == clfcc_pkg::CHAR_LF;
    assign has_result = in_valid_reg && (is_nl || overrun);
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_fire    = in_valid_reg && (!has_result || out_free);
    assign rx.ready   = !in_valid_reg || s1_fire;
    assign cfg.ready  = 1'b1;

    assign result.valid        = out_valid_reg;
    assign result.verdict      = out_reg.verdict;
    assign result.frame_kind   = out_reg.frame_kind;
    assign result.field_total  = out_reg.field_total;
    assign result.crc_value    = out_reg.crc_value;

    // Byte update terms
    assign crc_new  = clfcc_pkg::crc16_byte(running_crc_reg, in_byte_reg);
    assign is_digit = (in_byte_reg >= clfcc_pkg::CHAR_ZERO) &&
                      (in_byte_reg <= clfcc_pkg::CHAR_NINE);
    assign tail_acc = {1'b0, tail_value_reg, 3'b000} + {3'b000, tail_value_reg, 1'b0}
                    + {17'd0, in_byte_reg[3:0]};

    // Verdict for a newline or an overrun
    always_comb
    begin
        fields = (comma_total_reg == clfcc_pkg::CNT_MAX) ? clfcc_pkg::CNT_MAX
                                                          : comma_total_reg + 10'd1;
        kind = clfcc_pkg::KIND_UNKNOWN;
        if (comma_seen_reg && lead_len_reg == 2'd1)
        begin
            case (lead_char_reg)
                clfcc_pkg::CHAR_S: kind = clfcc_pkg::KIND_SENSOR;
                clfcc_pkg::CHAR_E: kind = clfcc_pkg::KIND_EST;
                clfcc_pkg::CHAR_Z: kind = clfcc_pkg::KIND_CALIB;
                default:           kind = clfcc_pkg::KIND_UNKNOWN;
            endcase
        end
        // value above 65535 shows as bit 16 set
        tail_ok  = comma_seen_reg && !tail_empty_reg && !tail_bad_reg &&
                   !tail_value_reg[clfcc_pkg::TAIL_W-1];
        rcrc     = tail_ok ? tail_value_reg[clfcc_pkg::CRC_W-1:0] : '0;
        expected = (kind == clfcc_pkg::KIND_SENSOR) ? sensor_fields_reg : est_fields_reg;

        if (overrun || return_seen_reg || !tail_ok)
        begin
            verdict = clfcc_pkg::VERDICT_FRAMING;
        end
        else if (comma_crc_reg != rcrc)
        begin
            verdict = clfcc_pkg::VERDICT_CRC;
        end
        else if (kind == clfcc_pkg::KIND_CALIB)
        begin
            verdict = (fields == calib_fields_reg) ? clfcc_pkg::VERDICT_OK
                                                   : clfcc_pkg::VERDICT_BAD_CALIB;
        end
        else if (kind == clfcc_pkg::KIND_UNKNOWN)
        begin
            verdict = clfcc_pkg::VERDICT_FRAMING;
        end
        else if (fields < expected)
        begin
            verdict = clfcc_pkg::VERDICT_FEW;
        end
        else if (fields > expected)
        begin
            verdict = clfcc_pkg::VERDICT_MANY;
        end
        else
        begin
            verdict = clfcc_pkg::VERDICT_OK;
        end

        // overrun by an ordinary byte drops the line with zeroed fields
        if (is_nl)
        begin
            res_next.verdict      = verdict;
            res_next.frame_kind   = kind;
            res_next.field_total  = fields;
            res_next.crc_value    = rcrc;
        end
        else
        begin
            res_next.verdict      = clfcc_pkg::VERDICT_FRAMING;
            res_next.frame_kind   = clfcc_pkg::KIND_UNKNOWN;
            res_next.field_total  = '0;
            res_next.crc_value    = '0;
        end
    end

    // Line state next value
    always_comb
    begin
        running_crc_next = running_crc_reg;
        comma_crc_next   = comma_crc_reg;
        comma_seen_next  = comma_seen_reg;
        tail_value_next  = tail_value_reg;
        tail_empty_next  = tail_empty_reg;
        tail_bad_next    = tail_bad_reg;
        line_bytes_next  = line_bytes_reg;
        comma_total_next = comma_total_reg;
        return_seen_next = return_seen_reg;
        lead_char_next   = lead_char_reg;
        lead_len_next    = lead_len_reg;

        if (has_result)
        begin
            running_crc_next = clfcc_pkg::CRC_INIT;
            comma_crc_next   = clfcc_pkg::CRC_INIT;
            comma_seen_next  = 1'b0;
            tail_value_next  = '0;
            tail_empty_next  = 1'b1;
            tail_bad_next    = 1'b0;
            line_bytes_next  = '0;
            comma_total_next = '0;
            return_seen_next = 1'b0;
            lead_char_next   = '0;
            lead_len_next    = '0;
        end
        else
        begin
            line_bytes_next  = line_inc[clfcc_pkg::CNT_W-1:0];
            running_crc_next = crc_new;
            if (in_byte_reg == clfcc_pkg::CHAR_CR)
            begin
                return_seen_next = 1'b1;
            end
            if (in_byte_reg == clfcc_pkg::CHAR_COMMA)
            begin
                comma_crc_next  = crc_new;
                comma_seen_next = 1'b1;
                if (comma_total_reg != clfcc_pkg::CNT_MAX)
                begin
                    comma_total_next = comma_total_reg + 10'd1;
                end
                tail_value_next = '0;
                tail_empty_next = 1'b1;
                tail_bad_next   = 1'b0;
            end
            else
            begin
                if (!comma_seen_reg)
                begin
                    if (lead_len_reg == 2'd0)
                    begin
                        lead_char_next = in_byte_reg;
                    end
                    if (lead_len_reg != 2'd2)
                    begin
                        lead_len_next = lead_len_reg + 2'd1;
                    end
                end
                tail_empty_next = 1'b0;
                if (is_digit)
                begin
                    tail_value_next = (tail_acc > {4'd0, clfcc_pkg::TAIL_SAT})
                                    ? clfcc_pkg::TAIL_SAT
                                    : tail_acc[clfcc_pkg::TAIL_W-1:0];
                end
                else
                begin
                    tail_bad_next = 1'b1;
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg      <= clfcc_pkg::MAX_LINE_RST;
            sensor_fields_reg <= clfcc_pkg::SENSOR_FIELDS_RST;
            est_fields_reg    <= clfcc_pkg::EST_FIELDS_RST;
            calib_fields_reg  <= clfcc_pkg::CALIB_FIELDS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                clfcc_pkg::REG_MAX_LINE_BYTES: max_line_reg      <= cfg.data;
                clfcc_pkg::REG_SENSOR_FIELDS:  sensor_fields_reg <= cfg.data;
                clfcc_pkg::REG_EST_FIELDS:     est_fields_reg    <= cfg.data;
                clfcc_pkg::REG_CALIB_FIELDS:   calib_fields_reg  <= cfg.data;
                default:                       ;
            endcase
        end
    end

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            out_reg <= res_next;
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= clfcc_pkg::CRC_INIT;
            comma_crc_reg   <= clfcc_pkg::CRC_INIT;
            comma_seen_reg  <= 1'b0;
            tail_value_reg  <= '0;
            tail_empty_reg  <= 1'b1;
            tail_bad_reg    <= 1'b0;
            line_bytes_reg  <= '0;
            comma_total_reg <= '0;
            return_seen_reg <= 1'b0;
            lead_char_reg   <= '0;
            lead_len_reg    <= '0;
        end
        else if (s1_fire)
        begin
            running_crc_reg <= running_crc_next;
            comma_crc_reg   <= comma_crc_next;
            comma_seen_reg  <= comma_seen_next;
            tail_value_reg  <= tail_value_next;
            tail_empty_reg  <= tail_empty_next;
            tail_bad_reg    <= tail_bad_next;
            line_bytes_reg  <= line_bytes_next;
            comma_total_reg <= comma_total_next;
            return_seen_reg <= return_seen_next;
            lead_char_reg   <= lead_char_next;
            lead_len_reg    <= lead_len_next;
        end
    end

    // Checks
    `CLFCC_ASSERT_IMP(a_stall_blocks_input, has_result && !out_free, !rx.ready)
    `CLFCC_ASSERT_NXT(a_verdict_clears_line, s1_fire && has_result,
                      line_bytes_reg == '0 && comma_total_reg == '0 && !comma_seen_reg)
    `CLFCC_ASSERT_IMP(a_tail_saturates, 1'b1, tail_value_reg <= clfcc_pkg::TAIL_SAT)
    `CLFCC_ASSERT_IMP(a_ok_has_kind, out_valid_reg && out_reg.verdict == clfcc_pkg::VERDICT_OK,
                      out_reg.frame_kind != clfcc_pkg::KIND_UNKNOWN)

endmodule
